>>> rtl/servo_hand_register_bank_unit_macros.svh
// Assertion macros shared by the RTL of the servo hand register bank.
`ifndef SERVO_HAND_REGISTER_BANK_UNIT_MACROS_SVH
`define SERVO_HAND_REGISTER_BANK_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked out of reset.
`define SHRB_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define SHRB_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define SHRB_ASSERT_IMP(label, clk, rstn, ante, cons)
`define SHRB_ASSERT_NXT(label, clk, rstn, ante, cons)

`endif

`endif

>>> rtl/shrb_pkg.sv
`timescale 1ns / 1ps

package shrb_pkg;

    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_READ   = 2'd1,
        CMD_APPLY  = 2'd2,
        CMD_STATUS = 2'd3
    } cmd_t;

    // input beat payload, last field in the lowest bits
    typedef struct packed {
        logic [15:0] status_value;
        logic [7:0]  param_count;
        logic [7:0]  servo_id;
        logic [9:0]  adc_sample;
        logic [7:0]  write_data;
        logic [15:0] addr;
    } in_item_t;

    typedef struct packed {
        logic       torques_applied;
        logic       reset_request;
        logic       silence_active;
        logic [7:0] read_data;
    } result_t;

    localparam int IN_BITS     = $bits(in_item_t);
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = $bits(result_t);
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [15:0] GOAL_BASE     = 16'h0040;
    localparam logic [15:0] TORQUE_BASE   = 16'h0080;
    localparam logic [15:0] POS_BASE      = 16'h0010;
    localparam logic [15:0] POS_TEMP_BASE = 16'h0040;
    localparam logic [15:0] RESET_ADDR    = 16'h0100;
    localparam logic [15:0] SILENCE_ADDR  = 16'h0101;
    localparam logic [15:0] ADC_ADDR      = 16'h0100;
    localparam logic [15:0] MODEL_LO_ADDR = 16'h0000;
    localparam logic [15:0] MODEL_HI_ADDR = 16'h0001;
    localparam logic [15:0] VERSION_ADDR  = 16'h0006;

    localparam logic [7:0] KEY_SET      = 8'hAB;
    localparam logic [7:0] KEY_CLEAR    = 8'hAC;
    localparam logic [7:0] MODEL_LO_VAL = 8'hFA;
    localparam logic [7:0] MODEL_HI_VAL = 8'hFB;
    localparam logic [7:0] VERSION_VAL  = 8'h01;
    localparam logic [7:0] UNMAPPED_VAL = 8'hFF;

    localparam logic [15:0] GOAL_RESET = 16'd2048;

    // floor(x/3) = (x*43) >> 7 holds for every x below 128
    localparam logic [6:0] DIV3_MUL   = 7'd43;
    localparam int         DIV3_SHIFT = 7;

endpackage

>>> rtl/servo_hand_register_bank_unit.sv
`timescale 1ns / 1ps
//  channel | direction | tdata (low bit up)                         | tuser
//  --------+-----------+--------------------------------------------+----------
//  s_      | in        | addr, write_data, adc_sample, servo_id,    | cmd
//          |           | param_count, status_value, zero pad to 72  |
//  m_      | out       | read_data, silence_active, reset_request,  | -
//          |           | torques_applied, zero pad to 16            |
//
//  One beat in and one beat out per cycle while m_tready is high; beats pass the
//  input register, then decode and register update into the result register.
//  Each result is a single decode pass over flop-based register arrays.
//  aresetn (synchronous) loads the bank and flags: goals to 2048, rest zero.
//  m_tready low holds the result; the input register still takes one more
//  beat, then s_tready drops until the result drains.
`include "servo_hand_register_bank_unit_macros.svh"

module servo_hand_register_bank_unit #(
    parameter int NUM_SERVOS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // addr[15:0], write_data[23:16], adc_sample[33:24], servo_id[41:34],
    // param_count[49:42], status_value[65:50], zero above
    input  logic [shrb_pkg::IN_TDATA_W-1:0]     s_tdata,
    // cmd[1:0]
    input  logic [1:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // read_data[7:0], silence_active[8], reset_request[9], torques_applied[10]
    output logic [shrb_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    localparam int IDX_W = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;
    localparam logic [15:0] GOAL_END   = 16'(shrb_pkg::GOAL_BASE + 2 * NUM_SERVOS);
    localparam logic [15:0] TORQUE_END = 16'(shrb_pkg::TORQUE_BASE + 2 * NUM_SERVOS);
    localparam logic [15:0] POS_END    = 16'(shrb_pkg::POS_BASE + 2 * NUM_SERVOS);
    localparam logic [15:0] PT_END     = 16'(shrb_pkg::POS_TEMP_BASE + 3 * NUM_SERVOS);
    localparam logic [7:0]  ID_MAX     = 8'(NUM_SERVOS);

    // input register
    logic                  in_valid_reg;
    shrb_pkg::in_item_t    in_item_reg;
    shrb_pkg::cmd_t        in_cmd_reg;

    // result register
    logic                  m_tvalid_reg;
    shrb_pkg::result_t     result_reg;
    shrb_pkg::result_t     result_next;

    // register bank
    logic [15:0] goal_pos_reg   [NUM_SERVOS];
    logic [15:0] goal_pos_next  [NUM_SERVOS];
    logic [7:0]  goal_low_reg   [NUM_SERVOS];
    logic [7:0]  goal_low_next  [NUM_SERVOS];
    logic [15:0] tq_shadow_reg  [NUM_SERVOS];
    logic [15:0] tq_shadow_next [NUM_SERVOS];
    logic [15:0] tq_active_reg  [NUM_SERVOS];
    logic [15:0] tq_active_next [NUM_SERVOS];
    logic [15:0] fb_pos_reg     [NUM_SERVOS];
    logic [15:0] fb_pos_next    [NUM_SERVOS];
    logic [7:0]  temp_reg       [NUM_SERVOS];
    logic [7:0]  temp_next      [NUM_SERVOS];
    logic        tq_pending_reg;
    logic        tq_pending_next;
    logic [15:0] adc_latch_reg;
    logic [15:0] adc_latch_next;
    logic        silence_reg;
    logic        silence_next;

    logic advance;

    // address decode
    logic [15:0]      addr;
    logic [15:0]      goal_off;
    logic [15:0]      tq_off;
    logic [15:0]      pos_off;
    logic [15:0]      pt_off;
    logic             goal_hit;
    logic             tq_hit;
    logic             pos_hit;
    logic             pt_hit;
    logic [IDX_W-1:0] goal_idx;
    logic [IDX_W-1:0] tq_idx;
    logic [IDX_W-1:0] pos_idx;
    logic [5:0]       pt_off6;
    logic [12:0]      pt_prod;
    logic [4:0]       pt_k;
    logic [5:0]       pt_rem;
    logic [IDX_W-1:0] pt_idx;
    logic [7:0]       id_m1;
    logic [IDX_W-1:0] sts_idx;
    logic             sts_id_ok;

    assign advance  = in_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(shrb_pkg::OUT_TDATA_W - shrb_pkg::OUT_BITS)'(0), result_reg};

    assign addr     = in_item_reg.addr;
    assign goal_off = addr - shrb_pkg::GOAL_BASE;
    assign tq_off   = addr - shrb_pkg::TORQUE_BASE;
    assign pos_off  = addr - shrb_pkg::POS_BASE;
    assign pt_off   = addr - shrb_pkg::POS_TEMP_BASE;
    assign goal_hit = (addr >= shrb_pkg::GOAL_BASE) && (addr < GOAL_END);
    assign tq_hit   = (addr >= shrb_pkg::TORQUE_BASE) && (addr < TORQUE_END);
    assign pos_hit  = (addr >= shrb_pkg::POS_BASE) && (addr < POS_END);
    assign pt_hit   = (addr >= shrb_pkg::POS_TEMP_BASE) && (addr < PT_END);
    assign goal_idx = goal_off[IDX_W:1];
    assign tq_idx   = tq_off[IDX_W:1];
    assign pos_idx  = pos_off[IDX_W:1];

    // 3-byte window: offset stays below 48, so divide by 3 via reciprocal
    assign pt_off6  = pt_off[5:0];
    assign pt_prod  = 13'(pt_off6) * 13'(shrb_pkg::DIV3_MUL);
    assign pt_k     = pt_prod[shrb_pkg::DIV3_SHIFT +: 5];
    assign pt_rem   = pt_off6 - 6'({pt_k, 1'b0} + {1'b0, pt_k});
    assign pt_idx   = pt_k[IDX_W-1:0];

    assign id_m1     = in_item_reg.servo_id - 8'd1;
    assign sts_idx   = id_m1[IDX_W-1:0];
    assign sts_id_ok = (in_item_reg.servo_id != 8'd0) && (in_item_reg.servo_id <= ID_MAX);

    always_comb begin
        goal_pos_next   = goal_pos_reg;
        goal_low_next   = goal_low_reg;
        tq_shadow_next  = tq_shadow_reg;
        tq_active_next  = tq_active_reg;
        fb_pos_next     = fb_pos_reg;
        temp_next       = temp_reg;
        tq_pending_next = tq_pending_reg;
        adc_latch_next  = adc_latch_reg;
        silence_next    = silence_reg;
        result_next     = '0;

        case (in_cmd_reg)
            shrb_pkg::CMD_WRITE: begin
                if (goal_hit) begin
                    if (addr[0]) begin
                        goal_pos_next[goal_idx] = {in_item_reg.write_data,
                                                   goal_low_reg[goal_idx]};
                    end else begin
                        goal_low_next[goal_idx] = in_item_reg.write_data;
                    end
                end
                if (tq_hit) begin
                    if (addr[0]) begin
                        tq_shadow_next[tq_idx][15:8] = in_item_reg.write_data;
                    end else begin
                        tq_shadow_next[tq_idx][7:0] = in_item_reg.write_data;
                    end
                    tq_pending_next = 1'b1;
                end
                if (addr == shrb_pkg::RESET_ADDR
                        && in_item_reg.write_data == shrb_pkg::KEY_SET) begin
                    result_next.reset_request = 1'b1;
                end
                if (addr == shrb_pkg::SILENCE_ADDR
                        && in_item_reg.write_data == shrb_pkg::KEY_SET) begin
                    silence_next = 1'b1;
                end
                if (addr == shrb_pkg::SILENCE_ADDR
                        && in_item_reg.write_data == shrb_pkg::KEY_CLEAR) begin
                    silence_next = 1'b0;
                end
            end
            shrb_pkg::CMD_READ: begin
                // priority follows the read map order
                if (addr == shrb_pkg::MODEL_LO_ADDR) begin
                    result_next.read_data = shrb_pkg::MODEL_LO_VAL;
                end else if (addr == shrb_pkg::MODEL_HI_ADDR) begin
                    result_next.read_data = shrb_pkg::MODEL_HI_VAL;
                end else if (addr == shrb_pkg::VERSION_ADDR) begin
                    result_next.read_data = shrb_pkg::VERSION_VAL;
                end else if (pos_hit) begin
                    result_next.read_data = addr[0] ? fb_pos_reg[pos_idx][15:8]
                                                    : fb_pos_reg[pos_idx][7:0];
                end else if (pt_hit) begin
                    if (pt_rem == 6'd0) begin
                        result_next.read_data = fb_pos_reg[pt_idx][7:0];
                    end else if (pt_rem == 6'd1) begin
                        result_next.read_data = fb_pos_reg[pt_idx][15:8];
                    end else begin
                        result_next.read_data = temp_reg[pt_idx];
                    end
                end else if (addr == shrb_pkg::ADC_ADDR || addr == POS_END
                             || addr == PT_END) begin
                    adc_latch_next        = {6'd0, in_item_reg.adc_sample};
                    result_next.read_data = in_item_reg.adc_sample[7:0];
                end else if (addr == shrb_pkg::ADC_ADDR + 16'd1 || addr == POS_END + 16'd1
                             || addr == PT_END + 16'd1) begin
                    result_next.read_data = adc_latch_reg[15:8];
                end else begin
                    result_next.read_data = shrb_pkg::UNMAPPED_VAL;
                end
            end
            shrb_pkg::CMD_APPLY: begin
                if (tq_pending_reg) begin
                    tq_active_next              = tq_shadow_reg;
                    result_next.torques_applied = 1'b1;
                end
                tq_pending_next = 1'b0;
            end
            shrb_pkg::CMD_STATUS: begin
                if (sts_id_ok) begin
                    if (in_item_reg.param_count == 8'd1) begin
                        temp_next[sts_idx] = in_item_reg.status_value[7:0];
                    end else if (in_item_reg.param_count == 8'd2) begin
                        fb_pos_next[sts_idx] = in_item_reg.status_value;
                    end
                end
            end
            default: begin
                result_next = '0;
            end
        endcase

        result_next.silence_active = silence_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            tq_pending_reg <= 1'b0;
            adc_latch_reg  <= '0;
            silence_reg    <= 1'b0;
            for (int i = 0; i < NUM_SERVOS; i++) begin
                goal_pos_reg[i]  <= shrb_pkg::GOAL_RESET;
                goal_low_reg[i]  <= '0;
                tq_shadow_reg[i] <= '0;
                tq_active_reg[i] <= '0;
                fb_pos_reg[i]    <= '0;
                temp_reg[i]      <= '0;
            end
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                m_tvalid_reg   <= 1'b1;
                goal_pos_reg   <= goal_pos_next;
                goal_low_reg   <= goal_low_next;
                tq_shadow_reg  <= tq_shadow_next;
                tq_active_reg  <= tq_active_next;
                fb_pos_reg     <= fb_pos_next;
                temp_reg       <= temp_next;
                tq_pending_reg <= tq_pending_next;
                adc_latch_reg  <= adc_latch_next;
                silence_reg    <= silence_next;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg <= shrb_pkg::in_item_t'(s_tdata[shrb_pkg::IN_BITS-1:0]);
            in_cmd_reg  <= shrb_pkg::cmd_t'(s_tuser);
        end
        if (advance) begin
            result_reg <= result_next;
        end
    end

    `SHRB_ASSERT_IMP(a_stall_holds_input, aclk, aresetn, !s_tready, in_valid_reg)
    `SHRB_ASSERT_NXT(a_advance_fills_out, aclk, aresetn, advance, m_tvalid_reg)
    `SHRB_ASSERT_NXT(a_apply_clears_pend, aclk, aresetn, advance && in_cmd_reg == shrb_pkg::CMD_APPLY, !tq_pending_reg)
    `SHRB_ASSERT_IMP(a_flags_exclusive, aclk, aresetn, m_tvalid_reg, !(result_reg.reset_request && result_reg.torques_applied))

endmodule
